// ----- rtl/tte_pkg.sv -----
// tte_pkg: shared constants, types and the controller state encoding for the
// tap tempo estimator. No dependencies.
`timescale 1ns / 1ps

package tte_pkg;

  localparam int unsigned SOURCES_DEF = 4;
  localparam int unsigned RING_DEPTH  = 4;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned BPM_W       = 16;
  localparam int unsigned POS_W       = 2;

  // 60e6 us per minute, 26 bits wide
  localparam int unsigned USPM_W = 26;
  localparam logic [USPM_W-1:0] US_PER_MINUTE = USPM_W'(60000000);
  localparam logic [BPM_W-1:0]  BPM_MAX = '1;

  // divide-by-three unit: 34-bit sum padded to 5 digits of 8 bits
  localparam int unsigned SUM_W       = TIME_W + 2;
  localparam int unsigned DIV3_DIGIT  = 8;
  localparam int unsigned DIV3_STEPS  = 5;
  localparam int unsigned DIV3_NUM_W  = DIV3_DIGIT * DIV3_STEPS;
  localparam int unsigned CNT_W       = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RATIO,
    ST_DIV3,
    ST_TEST,
    ST_DIVB,
    ST_WB,
    ST_DONE
  } state_e;

  // one memory row holds all state of one source
  typedef struct packed {
    logic [RING_DEPTH-1:0][TIME_W-1:0] tap;
    logic [POS_W-1:0]                  pos;
    logic [TIME_W-1:0]                 prev;
    logic [BPM_W-1:0]                  bpm;
    logic [TIME_W-1:0]                 interval;
    logic [TIME_W-1:0]                 lock_time;
  } src_row_t;

endpackage

// ----- rtl/tap_tempo_estimator.sv -----
// tap_tempo_estimator: per-source tap ring and tempo estimator built around
// one synchronous state memory, a divide-by-three unit and a bit-serial divider.
// Depends on tte_pkg.
`timescale 1ns / 1ps

// Usage
//   slave channel (s_axis_*): one tap per transfer, tuser carries the source
//   number, tdata the 32-bit microsecond timestamp
//   master channel (m_axis_*): exactly one result per tap, in tap order;
//   tuser holds the accepted and locked flags, tdata the source's current
//   bpm, beat interval and lock time
//   one tap is processed at a time; s_axis_tready is high only while the
//   controller is idle
//   a tap that locks passes memory read, ratio test, 5 divide-by-three
//   steps, 26 divider steps for the bpm, write back and output load; a
//   non-locking tap skips the divider and an ignored tap goes from the read
//   straight to the output load. The bit-serial bpm divider is the longest
//   part of the work on a locking tap
//   reset clears the controller, the output valid flag and the row valid bits;
//   a row that was never written reads as all zero, so no clearing pass runs
//   a stalled receiver holds the result in the output register; the next tap
//   is still taken and worked on, and waits at the end until the output
//   register frees up
//   source numbers not below SOURCES give an all-zero result and touch no
//   state
module tap_tempo_estimator #(
  parameter int unsigned SOURCES = tte_pkg::SOURCES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] tap_time
  input  logic [1:0]  s_axis_tuser,   // [1:0] source
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] bpm, [47:16] beat_interval,
                                      // [79:48] lock_time
  output logic [1:0]  m_axis_tuser    // [0] accepted, [1] locked
);

  localparam int unsigned IdxW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned ExtW = IdxW + 2;
  localparam int unsigned RowW = $bits(tte_pkg::src_row_t);

  // ---------------------------------------------------------------------
  // state memory: one row per source, valid bits stand in for the reset
  // ---------------------------------------------------------------------
  logic [RowW-1:0]     mem [SOURCES];
  logic [SOURCES-1:0]  row_vld_q;
  tte_pkg::src_row_t   row_rd_q;
  logic                mem_we;
  tte_pkg::src_row_t   row_wr;

  tte_pkg::state_e state_q, state_d;

  // captured tap
  logic [ExtW-1:0]     src_ext;
  logic                in_range;
  logic [IdxW-1:0]     idx_in;
  logic [IdxW-1:0]     idx_q;
  logic                in_range_q;
  logic [31:0]         tap_q;

  // working row and intervals
  tte_pkg::src_row_t   work_q, work_d;
  logic [31:0]         d0_q, d1_q, d2_q;
  logic [31:0]         d0_d, d1_d, d2_d;
  logic                ratio_ok_q, ratio_ok_d;
  logic                lock_q, lock_d;

  // divide-by-three unit
  logic [tte_pkg::DIV3_NUM_W-1:0] d3_num_q, d3_num_d;
  logic [tte_pkg::DIV3_NUM_W-1:0] d3_quo_q, d3_quo_d;
  logic [1:0]                     d3_rem_q, d3_rem_d;
  logic [tte_pkg::DIV3_DIGIT-1:0] d3_digit;
  logic [1:0]                     d3_rem_step;
  logic [31:0]                    avg;

  // bit-serial bpm divider
  logic [31:0]                 br_rem_q, br_rem_d;
  logic [tte_pkg::USPM_W-1:0]  br_quo_q, br_quo_d;
  logic [32:0]                 br_trial;
  logic                        br_fit;
  logic [tte_pkg::BPM_W-1:0]   bpm_sat;

  logic [tte_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  // result staging and output register
  logic        res_acc_q, res_acc_d, res_lock_q, res_lock_d;
  logic [79:0] res_data_q, res_data_d;
  logic        out_vld_q;
  logic [79:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_load;

  tte_pkg::src_row_t row_eff;
  logic [31:0]       t0, t1, t2;
  logic [tte_pkg::SUM_W-1:0] sum;

  // a < 1.25 * b, exact
  function automatic logic below_ratio(input logic [31:0] a, input logic [31:0] b);
    logic [34:0] a4;
    logic [34:0] b5;
    a4 = {1'b0, a, 2'b00};
    b5 = {1'b0, b, 2'b00} + {3'b000, b};
    return a4 < b5;
  endfunction

  assign src_ext  = {IdxW'(0), s_axis_tuser};
  assign in_range = src_ext < ExtW'(SOURCES);
  assign idx_in   = src_ext[IdxW-1:0];

  assign s_axis_tready = (state_q == tte_pkg::ST_IDLE);

  // memory read and write
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready && in_range) begin
      row_rd_q <= tte_pkg::src_row_t'(mem[idx_in]);
    end
    if (mem_we) begin
      mem[idx_q] <= RowW'(row_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (mem_we) begin
      row_vld_q[idx_q] <= 1'b1;
    end
  end

  // row seen by the logic: unwritten rows read as zero
  always_comb begin
    row_eff = '0;
    if (in_range_q && row_vld_q[idx_q]) begin
      row_eff = row_rd_q;
    end
  end

  // intervals in time order after the new tap lands at pos
  always_comb begin
    t0   = row_eff.tap[row_eff.pos + 2'd1];
    t1   = row_eff.tap[row_eff.pos + 2'd2];
    t2   = row_eff.tap[row_eff.pos + 2'd3];
    d0_d = t1 - t0;
    d1_d = t2 - t1;
    d2_d = tap_q - t2;
  end

  assign sum = {2'b00, d0_q} + {2'b00, d1_q} + {2'b00, d2_q};

  // one 8-bit digit of the divide by three
  always_comb begin
    logic [2:0] x;
    d3_digit    = '0;
    d3_rem_step = d3_rem_q;
    x           = '0;
    for (int k = tte_pkg::DIV3_DIGIT - 1; k >= 0; k--) begin
      x = {d3_rem_step, d3_num_q[tte_pkg::DIV3_NUM_W - tte_pkg::DIV3_DIGIT + k]};
      if (x >= 3'd3) begin
        d3_digit[k] = 1'b1;
        d3_rem_step = 2'(x - 3'd3);
      end else begin
        d3_rem_step = x[1:0];
      end
    end
  end

  assign avg = d3_quo_q[31:0];

  // one bit of 60e6 / avg
  assign br_trial = {br_rem_q, tte_pkg::US_PER_MINUTE[cnt_q]};
  assign br_fit   = br_trial >= {1'b0, avg};
  assign bpm_sat  = (|br_quo_q[tte_pkg::USPM_W-1:tte_pkg::BPM_W]) ?
                    tte_pkg::BPM_MAX : br_quo_q[tte_pkg::BPM_W-1:0];

  // write-back row
  always_comb begin
    row_wr      = work_q;
    row_wr.pos  = work_q.pos + 2'd1;
    row_wr.prev = tap_q;
    if (lock_q) begin
      row_wr.bpm       = bpm_sat;
      row_wr.interval  = avg;
      row_wr.lock_time = tap_q;
    end
  end

  // controller
  always_comb begin
    state_d    = state_q;
    work_d     = work_q;
    ratio_ok_d = ratio_ok_q;
    lock_d     = lock_q;
    d3_num_d   = d3_num_q;
    d3_quo_d   = d3_quo_q;
    d3_rem_d   = d3_rem_q;
    br_rem_d   = br_rem_q;
    br_quo_d   = br_quo_q;
    cnt_d      = cnt_q;
    res_acc_d  = res_acc_q;
    res_lock_d = res_lock_q;
    res_data_d = res_data_q;
    mem_we     = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      tte_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = tte_pkg::ST_READ;
        end
      end
      tte_pkg::ST_READ: begin
        res_acc_d  = 1'b0;
        res_lock_d = 1'b0;
        res_data_d = {row_eff.lock_time, row_eff.interval, row_eff.bpm};
        if (!in_range_q || tap_q == row_eff.prev) begin
          // out-of-range source reads as a zero row; a repeated stamp is ignored
          state_d = tte_pkg::ST_DONE;
        end else begin
          work_d                  = row_eff;
          work_d.tap[row_eff.pos] = tap_q;
          state_d                 = tte_pkg::ST_RATIO;
        end
      end
      tte_pkg::ST_RATIO: begin
        ratio_ok_d = below_ratio(d1_q, d0_q) && below_ratio(d2_q, d0_q) &&
                     below_ratio(d0_q, d2_q);
        d3_num_d   = {(tte_pkg::DIV3_NUM_W - tte_pkg::SUM_W)'(0), sum};
        d3_quo_d   = '0;
        d3_rem_d   = '0;
        cnt_d      = '0;
        state_d    = tte_pkg::ST_DIV3;
      end
      tte_pkg::ST_DIV3: begin
        d3_num_d = d3_num_q << tte_pkg::DIV3_DIGIT;
        d3_quo_d = {d3_quo_q[tte_pkg::DIV3_NUM_W-tte_pkg::DIV3_DIGIT-1:0], d3_digit};
        d3_rem_d = d3_rem_step;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == tte_pkg::CNT_W'(tte_pkg::DIV3_STEPS - 1)) begin
          state_d = tte_pkg::ST_TEST;
        end
      end
      tte_pkg::ST_TEST: begin
        lock_d   = ratio_ok_q && (avg != '0);
        br_rem_d = '0;
        br_quo_d = '0;
        cnt_d    = tte_pkg::CNT_W'(tte_pkg::USPM_W - 1);
        state_d  = (ratio_ok_q && (avg != '0)) ? tte_pkg::ST_DIVB : tte_pkg::ST_WB;
      end
      tte_pkg::ST_DIVB: begin
        br_rem_d = br_fit ? 32'(br_trial - {1'b0, avg}) : br_trial[31:0];
        br_quo_d = {br_quo_q[tte_pkg::USPM_W-2:0], br_fit};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = tte_pkg::ST_WB;
        end
      end
      tte_pkg::ST_WB: begin
        mem_we     = 1'b1;
        res_acc_d  = 1'b1;
        res_lock_d = lock_q;
        res_data_d = {row_wr.lock_time, row_wr.interval, row_wr.bpm};
        state_d    = tte_pkg::ST_DONE;
      end
      tte_pkg::ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = tte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tte_pkg::ST_IDLE;
      cnt_q     <= '0;
      lock_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lock_q  <= (state_q == tte_pkg::ST_READ) ? 1'b0 : lock_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      idx_q      <= idx_in;
      in_range_q <= in_range;
      tap_q      <= s_axis_tdata;
    end
    if (state_q == tte_pkg::ST_READ) begin
      d0_q <= d0_d;
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
    work_q     <= work_d;
    ratio_ok_q <= ratio_ok_d;
    d3_num_q   <= d3_num_d;
    d3_quo_q   <= d3_quo_d;
    d3_rem_q   <= d3_rem_d;
    br_rem_q   <= br_rem_d;
    br_quo_q   <= br_quo_d;
    res_acc_q  <= res_acc_d;
    res_lock_q <= res_lock_d;
    res_data_q <= res_data_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_user_q <= {res_lock_q, res_acc_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_we_only_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == tte_pkg::ST_WB))
    else $error("state memory written outside write back");

  a_lock_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("locked result without accepted tap");

  a_divb_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tte_pkg::ST_DIVB) |-> (avg != '0))
    else $error("bpm divider running with zero divisor");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == tte_pkg::ST_READ))
    else $error("accepted tap did not start a memory read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule

// ----- tb/tte_tempo_checker.sv -----
// tte_tempo_checker: watches both stream channels of the tap tempo estimator,
// predicts each tap's result from its own copy of the per-source state and compares.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_tempo_checker #(
  parameter int unsigned SOURCES = tte_pkg::SOURCES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tap_valid_i,
  input  logic        tap_ready_i,
  input  logic [31:0] tap_time_i,    // [31:0] tap_time
  input  logic [1:0]  tap_source_i,  // [1:0] source
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [79:0] res_data_i,    // [15:0] bpm, [47:16] beat_interval, [79:48] lock_time
  input  logic [1:0]  res_flags_i,   // [0] accepted, [1] locked
  output int          errors_o,
  output int          outstanding_o,
  output int          results_o,
  output int          locks_o
);

  typedef struct packed {
    logic                       accepted;
    logic                       locked;
    logic [tte_pkg::BPM_W-1:0]  bpm;
    logic [tte_pkg::TIME_W-1:0] beat_interval;
    logic [tte_pkg::TIME_W-1:0] lock_time;
  } tempo_result_t;

  // per-source copy of the estimator state
  logic [tte_pkg::TIME_W-1:0] stamps        [SOURCES][tte_pkg::RING_DEPTH];
  logic [tte_pkg::POS_W-1:0]  slot          [SOURCES];
  logic [tte_pkg::TIME_W-1:0] last_stamp    [SOURCES];
  logic [tte_pkg::BPM_W-1:0]  cur_bpm       [SOURCES];
  logic [tte_pkg::TIME_W-1:0] cur_interval  [SOURCES];
  logic [tte_pkg::TIME_W-1:0] cur_lock_time [SOURCES];

  tempo_result_t expected_tempo_q [$];

  // a < 1.25 * b without rounding
  function automatic logic under_five_quarters(input logic [tte_pkg::TIME_W-1:0] a,
                                               input logic [tte_pkg::TIME_W-1:0] b);
    return (64'(a) << 2) < (64'(b) * 64'd5);
  endfunction

  task automatic estimate_tempo(input logic [1:0] src,
                                input logic [tte_pkg::TIME_W-1:0] stamp);
    tempo_result_t              r;
    logic [tte_pkg::POS_W-1:0]  p, i0, i1, i2;
    logic [tte_pkg::TIME_W-1:0] d0, d1, d2, avg, quot;
    logic [tte_pkg::SUM_W-1:0]  sum;
    r = '0;
    if (src < SOURCES) begin
      if (stamp != last_stamp[src]) begin
        r.accepted = 1'b1;
        p  = slot[src];
        i0 = p + tte_pkg::POS_W'(1);
        i1 = p + tte_pkg::POS_W'(2);
        i2 = p + tte_pkg::POS_W'(3);
        stamps[src][p] = stamp;
        // intervals oldest first, modulo 2^32
        d0 = stamps[src][i1] - stamps[src][i0];
        d1 = stamps[src][i2] - stamps[src][i1];
        d2 = stamp - stamps[src][i2];
        if (under_five_quarters(d1, d0) && under_five_quarters(d2, d0) &&
            under_five_quarters(d0, d2)) begin
          sum = tte_pkg::SUM_W'(d0) + tte_pkg::SUM_W'(d1) + tte_pkg::SUM_W'(d2);
          avg = tte_pkg::TIME_W'(sum / 3);
          if (avg != '0) begin
            quot = tte_pkg::TIME_W'(tte_pkg::US_PER_MINUTE) / avg;
            cur_bpm[src]       = (quot > tte_pkg::TIME_W'(tte_pkg::BPM_MAX)) ?
                                 tte_pkg::BPM_MAX : quot[tte_pkg::BPM_W-1:0];
            cur_interval[src]  = avg;
            cur_lock_time[src] = stamp;
            r.locked = 1'b1;
          end
        end
        last_stamp[src] = stamp;
        slot[src] = p + tte_pkg::POS_W'(1);
      end
      r.bpm           = cur_bpm[src];
      r.beat_interval = cur_interval[src];
      r.lock_time     = cur_lock_time[src];
    end
    expected_tempo_q.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [tte_pkg::TIME_W-1:0] want,
                             input logic [tte_pkg::TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tempo_result_t want;
    if (!rst_ni) begin
      foreach (stamps[s, k]) stamps[s][k] = '0;
      foreach (slot[s]) begin
        slot[s]          = '0;
        last_stamp[s]    = '0;
        cur_bpm[s]       = '0;
        cur_interval[s]  = '0;
        cur_lock_time[s] = '0;
      end
      expected_tempo_q.delete();
      errors_o      = 0;
      outstanding_o = 0;
      results_o     = 0;
      locks_o       = 0;
    end else begin
      // results first, so a tap taken in this cycle cannot answer a stray result
      if (res_valid_i && res_ready_i) begin
        if (expected_tempo_q.size() == 0) begin
          $error("result transfer with no tap waiting for it");
          errors_o++;
        end else begin
          want = expected_tempo_q.pop_front();
          results_o++;
          if (want.locked) locks_o++;
          check_field("accepted", tte_pkg::TIME_W'(want.accepted),
                      tte_pkg::TIME_W'(res_flags_i[0]));
          check_field("locked", tte_pkg::TIME_W'(want.locked),
                      tte_pkg::TIME_W'(res_flags_i[1]));
          check_field("bpm", tte_pkg::TIME_W'(want.bpm),
                      tte_pkg::TIME_W'(res_data_i[15:0]));
          check_field("beat_interval", want.beat_interval, res_data_i[47:16]);
          check_field("lock_time", want.lock_time, res_data_i[79:48]);
        end
      end
      if (tap_valid_i && tap_ready_i) estimate_tempo(tap_source_i, tap_time_i);
      outstanding_o = expected_tempo_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: stimulus and verdict for the tap tempo estimator; taps are driven
// on the slave stream, results drained on the master stream and checked by
// tte_tempo_checker. Depends on tte_pkg, tap_tempo_estimator and tte_tempo_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int PHASE_TAPS   = 275;     // random taps per pacing phase
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;      // idle pause after the final drain
  localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest correct run

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] tap_time
  logic [1:0]  s_axis_tuser = '0;   // [1:0] source
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // [15:0] bpm, [47:16] beat_interval, [79:48] lock_time
  logic [1:0]  m_axis_tuser;        // [0] accepted, [1] locked

  int errors, outstanding, results, locks;
  int cycle_count = 0;
  int taps_sent = 0;

  // pacing: idle rates and hold_req set by the stimulus process, hold state kept by the receiver
  int tx_idle_pct = 12;
  int rx_idle_pct = 69;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // stimulus bookkeeping per source: last stamp sent and current beat gap
  logic [tte_pkg::TIME_W-1:0] last_sent [4] = '{default: '0};
  logic [tte_pkg::TIME_W-1:0] beat_gap  [4] = '{default: '0};

  logic [1:0]                 rnd_src;
  logic [tte_pkg::TIME_W-1:0] rnd_stamp, jitter;
  int                         roll;

  always #2 clk_i = ~clk_i;

  tap_tempo_estimator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  tte_tempo_checker tempo_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tap_valid_i  (s_axis_tvalid),
    .tap_ready_i  (s_axis_tready),
    .tap_time_i   (s_axis_tdata),
    .tap_source_i (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_flags_i  (m_axis_tuser),
    .errors_o     (errors),
    .outstanding_o(outstanding),
    .results_o    (results),
    .locks_o      (locks)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tap_tempo_estimator test failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever hold_req moves on;
  // the hold-off is counted here so the sender keeps offering taps meanwhile
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one tap transfer; entered and left at a falling edge, tvalid stays high on
  // exit so back-to-back taps never drop it within a step
  task automatic send_tap(input logic [1:0] src, input logic [tte_pkg::TIME_W-1:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= src;
    s_axis_tdata  <= stamp;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    taps_sent++;
    last_sent[src] = stamp;
  endtask

  // a run of evenly spaced taps
  task automatic send_steady(input logic [1:0] src,
                             input logic [tte_pkg::TIME_W-1:0] first,
                             input logic [tte_pkg::TIME_W-1:0] step, input int count);
    for (int n = 0; n < count; n++) send_tap(src, first + tte_pkg::TIME_W'(n) * step);
  endtask

  // sender pause until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    send_tap(2'd0, 32'h0000_0000);          // equals the reset previous tap: ignored
    send_tap(2'd0, 32'hFFFF_FFFF);          // largest stamp, ring still mostly empty
    send_steady(2'd1, 32'd1000000, 32'd500000, 5);  // 120 bpm lock
    send_tap(2'd1, last_sent[1]);           // repeated stamp reports the held tempo
    send_steady(2'd2, 32'd10, 32'd50, 4);   // tiny interval, bpm saturates
    send_steady(2'd3, 32'hFFFF_F000, 32'h600, 4);   // stamps wrap past zero
    send_steady(2'd3, last_sent[3] + 32'h5000_0000, 32'h5000_0000, 4);  // bpm of zero
    // ratio edges: interval exactly 5/4 of the first fails, just under passes
    send_tap(2'd0, 32'd100);
    send_tap(2'd0, 32'd500);
    send_tap(2'd0, 32'd1000);
    send_tap(2'd0, 32'd1400);
    send_tap(2'd0, 32'd1899);
    drain_results();

    // random part in three pacing phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 69;
        end
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req = hold_req + 1;   // fill the block while results cannot leave
        end
      endcase
      for (int n = 0; n < PHASE_TAPS; n++) begin
        rnd_src = 2'($urandom_range(3));
        roll = $urandom_range(99);
        if (roll < 6) begin
          rnd_stamp = last_sent[rnd_src];           // repeat, gets ignored
        end else if (roll < 14) begin
          rnd_stamp = $urandom();                   // noise, breaks the run
        end else begin
          // steady beat with a little jitter, new tempo now and then
          if (roll < 20 || beat_gap[rnd_src] == '0) begin
            case ($urandom_range(3))
              0: beat_gap[rnd_src] = $urandom_range(900, 1);
              1: beat_gap[rnd_src] = $urandom_range(100000, 900);
              2: beat_gap[rnd_src] = $urandom_range(32'h0400_0000, 100000);
              default: beat_gap[rnd_src] = $urandom_range(32'h5000_0000, 32'h0400_0000);
            endcase
          end
          jitter = beat_gap[rnd_src] >> 4;
          rnd_stamp = last_sent[rnd_src] + beat_gap[rnd_src] - jitter;
          if (jitter != '0) rnd_stamp = rnd_stamp + $urandom_range(2 * jitter, 0);
        end
        send_tap(rnd_src, rnd_stamp);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d taps on four sources, %0d results checked, %0d of them locked",
             taps_sent, results, locks);
    $display("three pacing phases, a %0d-cycle receiver hold-off and drain pauses",
             HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("tap_tempo_estimator test passed");
    end else begin
      $display("tap_tempo_estimator test failed");
    end
    $finish;
  end

endmodule
